/* rtl/latip_pkg.sv */
// Shared types, constants and codes for the lidar angle table interpolator.
package latip_pkg;

  // Default table geometry
  localparam int unsigned FacetsDef    = 4;
  localparam int unsigned ColumnsDef   = 65;
  localparam int unsigned MaxSetsDef   = 24;
  localparam int unsigned ReceiversDef = 8;

  // Fixed field widths
  localparam int unsigned LINE_W  = 10;
  localparam int unsigned SET_W   = 5;
  localparam int unsigned USED_W  = 4;
  localparam int unsigned RX_W    = 3;
  localparam int unsigned FRAC_W  = 8;
  localparam int unsigned ANGLE_W = 16;
  localparam int unsigned WORD_W  = 2 * ANGLE_W;
  localparam int unsigned CFG_IDX_W = 2;

  // Arithmetic constants
  localparam logic signed [16:0] ENC_BASE     = 17'sd8192;
  localparam logic [ANGLE_W-1:0] INSET_OFFSET = 16'd18;
  localparam logic signed [ANGLE_W-1:0] VIEW_LIMIT = 16'sd10922;

  // Configuration reset values
  localparam logic [SET_W-1:0]  SET_COUNT_RST = 5'd6;
  localparam logic [USED_W-1:0] RX_USED_RST   = 4'd8;
  localparam logic              INSET_EN_RST  = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SET_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RX_USED   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INSET_EN  = 2'd2;

  // Request codes
  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_ROW,
    ST_BASE,
    ST_ISSUE
  } state_e;

  typedef struct packed {
    logic                       req_type;
    logic [15:0]                entry_address;
    logic signed [ANGLE_W-1:0]  entry_h;
    logic signed [ANGLE_W-1:0]  entry_v;
    logic [1:0]                 facet;
    logic signed [15:0]         encoder_angle;
    logic [LINE_W-1:0]          scan_line;
  } in_t;

  typedef struct packed {
    logic [RX_W-1:0]            receiver;
    logic signed [ANGLE_W-1:0]  angle_h;
    logic signed [ANGLE_W-1:0]  angle_v;
    logic                       in_view;
    logic                       last;
  } out_t;

  // Per-read tag that travels with the memory read into the blend stage
  typedef struct packed {
    logic [RX_W-1:0]   receiver;
    logic              last;
    logic [FRAC_W-1:0] frac;
    logic              inset;
  } issue_meta_t;

endpackage

/* rtl/lidar_angle_table_interpolator_core.sv */
// Lookup sequencer, table address generation and configuration registers.
// Load word: written to the table at its accept edge if its address lies inside the table,
// next word taken in the next cycle. Lookup word: the bit-serial set remainder, then the
// index products (row, base), then one receiver per cycle from the dual-read table while
// the output takes words; the next word is taken only after the last receiver is issued,
// and output stalls delay that. A result passes the table read register and the output word register.
// Reset clears control and loads the configuration defaults (6 sets, 8 receivers, inset on);
// the table is not cleared and holds nothing defined until loaded.
module lidar_angle_table_interpolator_core #(
  parameter int unsigned FACETS    = latip_pkg::FacetsDef,
  parameter int unsigned COLUMNS   = latip_pkg::ColumnsDef,
  parameter int unsigned MAX_SETS  = latip_pkg::MaxSetsDef,
  parameter int unsigned RECEIVERS = latip_pkg::ReceiversDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  latip_pkg::in_t                  in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output latip_pkg::out_t                 out_data_o,
  input  logic                            cfg_we_i,
  input  logic [latip_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [latip_pkg::SET_W-1:0]     cfg_wdata_i
);

  localparam int unsigned DEPTH  = FACETS * COLUMNS * MAX_SETS * RECEIVERS;
  localparam int unsigned AW     = $clog2(DEPTH);
  localparam int unsigned ROW_W  = $clog2(FACETS * COLUMNS);
  localparam int unsigned PROD_W = $clog2(FACETS * COLUMNS * MAX_SETS);
  localparam int unsigned COL_W  = $clog2(COLUMNS);

  latip_pkg::state_e state_q, state_d;

  logic [latip_pkg::SET_W-1:0]  set_count_q;
  logic [latip_pkg::USED_W-1:0] rx_used_q;
  logic                         inset_en_q;

  logic [latip_pkg::SET_W-1:0]  sets_eff;
  logic [latip_pkg::USED_W-1:0] used_eff;

  logic                         in_acc, lookup_acc, load_we;
  logic [31:0]                  load_addr;

  logic [1:0]                   facet_mod;
  logic signed [16:0]           enc_sum;
  logic [15:0]                  enc_pos;
  logic [COL_W-1:0]             col_d;

  logic [1:0]                   facet_q;
  logic [COL_W-1:0]             col_q;
  logic [latip_pkg::FRAC_W-1:0] frac_q;
  logic [latip_pkg::LINE_W-1:0] line_q;

  logic [ROW_W-1:0]             row_q;
  logic [PROD_W-1:0]            prod_a_q, prod_b_q, prod_a_d;
  logic [AW-1:0]                base_a_q, base_b_q;
  logic [latip_pkg::USED_W-1:0] rcnt_q, rcnt_d;

  logic                         div_start, div_done;
  logic [latip_pkg::SET_W-1:0]  div_rem;

  logic                         rd_en, can_issue;
  logic [AW-1:0]                raddr_a, raddr_b;
  latip_pkg::issue_meta_t       meta;
  logic [latip_pkg::WORD_W-1:0] rdata_a, rdata_b;

  // Configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_count_q <= latip_pkg::SET_COUNT_RST;
      rx_used_q   <= latip_pkg::RX_USED_RST;
      inset_en_q  <= latip_pkg::INSET_EN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        latip_pkg::CFG_SET_COUNT: set_count_q <= cfg_wdata_i;
        latip_pkg::CFG_RX_USED:   rx_used_q   <= cfg_wdata_i[latip_pkg::USED_W-1:0];
        latip_pkg::CFG_INSET_EN:  inset_en_q  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (set_count_q == '0) begin
      sets_eff = latip_pkg::SET_W'(1);
    end else if (32'(set_count_q) > MAX_SETS) begin
      sets_eff = latip_pkg::SET_W'(MAX_SETS);
    end else begin
      sets_eff = set_count_q;
    end
    if (32'(rx_used_q) > RECEIVERS) begin
      used_eff = latip_pkg::USED_W'(RECEIVERS);
    end else begin
      used_eff = rx_used_q;
    end
  end

  // Input decode
  assign in_stall_o = (state_q != latip_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign lookup_acc = in_acc && (in_data_i.req_type == latip_pkg::REQ_LOOKUP);
  assign load_addr  = 32'(in_data_i.entry_address);
  assign load_we    = in_acc && (in_data_i.req_type == latip_pkg::REQ_LOAD) &&
                      (load_addr < 32'(DEPTH));

  always_comb begin
    facet_mod = in_data_i.facet;
    for (int k = 0; k < 3; k++) begin
      if (32'(facet_mod) >= FACETS) begin
        facet_mod = facet_mod - 2'(FACETS);
      end
    end
    enc_sum = 17'(in_data_i.encoder_angle) + latip_pkg::ENC_BASE;
    enc_pos = enc_sum[16] ? 16'd0 : enc_sum[15:0];
    if (32'(enc_pos[15:8]) > COLUMNS - 2) begin
      col_d = COL_W'(COLUMNS - 2);
    end else begin
      col_d = COL_W'(enc_pos[15:8]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (lookup_acc) begin
      facet_q <= facet_mod;
      col_q   <= col_d;
      frac_q  <= enc_pos[latip_pkg::FRAC_W-1:0];
      line_q  <= in_data_i.scan_line;
    end
  end

  // Index products: row, then set product, then receiver base for both columns
  assign prod_a_d = PROD_W'(32'(row_q) * 32'(sets_eff) + 32'(div_rem));

  always_ff @(posedge clk_i) begin
    row_q <= ROW_W'(32'(facet_q) * COLUMNS + 32'(col_q));
    if (state_q == latip_pkg::ST_ROW) begin
      prod_a_q <= prod_a_d;
      prod_b_q <= PROD_W'(32'(prod_a_d) + 32'(sets_eff));
    end
    if (state_q == latip_pkg::ST_BASE) begin
      base_a_q <= AW'(32'(prod_a_q) * RECEIVERS);
      base_b_q <= AW'(32'(prod_b_q) * RECEIVERS);
    end
  end

  latip_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (in_data_i.scan_line),
    .divisor_i  (sets_eff),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  // Sequencer
  always_comb begin
    state_d   = state_q;
    rcnt_d    = rcnt_q;
    div_start = 1'b0;
    rd_en     = 1'b0;
    unique case (state_q)
      latip_pkg::ST_IDLE: begin
        if (lookup_acc) begin
          div_start = 1'b1;
          state_d   = latip_pkg::ST_DIV;
        end
      end
      latip_pkg::ST_DIV: begin
        if (div_done) begin
          state_d = latip_pkg::ST_ROW;
        end
      end
      latip_pkg::ST_ROW: begin
        state_d = latip_pkg::ST_BASE;
      end
      latip_pkg::ST_BASE: begin
        rcnt_d  = '0;
        state_d = (used_eff == '0) ? latip_pkg::ST_IDLE : latip_pkg::ST_ISSUE;
      end
      latip_pkg::ST_ISSUE: begin
        // advance one receiver whenever the read stage frees up
        if (can_issue) begin
          rd_en  = 1'b1;
          rcnt_d = rcnt_q + latip_pkg::USED_W'(1);
          if (rcnt_d == used_eff) begin
            state_d = latip_pkg::ST_IDLE;
          end
        end
      end
      default: state_d = latip_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= latip_pkg::ST_IDLE;
      rcnt_q  <= '0;
    end else begin
      state_q <= state_d;
      rcnt_q  <= rcnt_d;
    end
  end

  assign raddr_a = base_a_q + AW'(rcnt_q);
  assign raddr_b = base_b_q + AW'(rcnt_q);

  always_comb begin
    meta.receiver = rcnt_q[latip_pkg::RX_W-1:0];
    meta.last     = (rcnt_q + latip_pkg::USED_W'(1)) == used_eff;
    meta.frac     = frac_q;
    meta.inset    = inset_en_q && (32'(line_q) >= 32'(sets_eff));
  end

  latip_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk_i     (clk_i),
    .we_i      (load_we),
    .waddr_i   (load_addr[AW-1:0]),
    .wdata_i   ({in_data_i.entry_h, in_data_i.entry_v}),
    .re_i      (rd_en),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  latip_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .issue_i     (rd_en),
    .meta_i      (meta),
    .rdata_a_i   (rdata_a),
    .rdata_b_i   (rdata_b),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .can_issue_o (can_issue)
  );

`ifndef SYNTHESIS
  a_read_in_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en |-> (state_q == latip_pkg::ST_ISSUE))
    else $error("table read outside issue state");

  a_read_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en |-> (rcnt_q < used_eff))
    else $error("receiver count beyond receivers in use");

  a_lookup_starts_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lookup_acc |=> (state_q == latip_pkg::ST_DIV))
    else $error("lookup did not start remainder");

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == latip_pkg::ST_DIV))
    else $error("remainder finished outside remainder state");

  a_no_load_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_we |-> (state_q == latip_pkg::ST_IDLE))
    else $error("table write during lookup");
`endif

endmodule

/* rtl/latip_div.sv */
// Restoring remainder unit: scan line modulo set count, one quotient bit per cycle.
module latip_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [latip_pkg::LINE_W-1:0] dividend_i,
  input  logic [latip_pkg::SET_W-1:0]  divisor_i,
  output logic                        done_o,
  output logic [latip_pkg::SET_W-1:0]  rem_o
);

  localparam int unsigned CNT_W = $clog2(latip_pkg::LINE_W + 1);

  logic                         busy_q, busy_d;
  logic                         done_q, done_d;
  logic [CNT_W-1:0]             cnt_q, cnt_d;
  logic [latip_pkg::LINE_W-1:0] dvd_q, dvd_d;
  logic [latip_pkg::SET_W-1:0]  dsr_q, dsr_d;
  logic [latip_pkg::SET_W-1:0]  rem_q, rem_d;
  logic [latip_pkg::SET_W:0]    trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    dsr_d  = dsr_q;
    rem_d  = rem_q;
    trial  = {rem_q, dvd_q[latip_pkg::LINE_W-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(latip_pkg::LINE_W);
      dvd_d  = dividend_i;
      dsr_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      // shift in the next dividend bit, subtract when it fits
      if (trial >= {1'b0, dsr_q}) begin
        rem_d = latip_pkg::SET_W'(trial - {1'b0, dsr_q});
      end else begin
        rem_d = trial[latip_pkg::SET_W-1:0];
      end
      dvd_d = {dvd_q[latip_pkg::LINE_W-2:0], 1'b0};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dsr_q <= dsr_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

/* rtl/latip_mem.sv */
// Calibration table memory: one write port, two registered read ports.
module latip_mem #(
  parameter int unsigned DEPTH = 2,
  parameter int unsigned AW    = 1
) (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [AW-1:0]                waddr_i,
  input  logic [latip_pkg::WORD_W-1:0] wdata_i,
  input  logic                         re_i,
  input  logic [AW-1:0]                raddr_a_i,
  input  logic [AW-1:0]                raddr_b_i,
  output logic [latip_pkg::WORD_W-1:0] rdata_a_o,
  output logic [latip_pkg::WORD_W-1:0] rdata_b_o
);

  logic [latip_pkg::WORD_W-1:0] mem_q [DEPTH];
  logic [latip_pkg::WORD_W-1:0] rdata_a_q, rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

/* rtl/latip_out.sv */
// Blend stage and output word register with stall handling.
module latip_out (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          issue_i,
  input  latip_pkg::issue_meta_t        meta_i,
  input  logic [latip_pkg::WORD_W-1:0]  rdata_a_i,
  input  logic [latip_pkg::WORD_W-1:0]  rdata_b_i,
  input  logic                          out_stall_i,
  output logic                          out_valid_o,
  output latip_pkg::out_t               out_data_o,
  output logic                          can_issue_o
);

  localparam int unsigned AW_ = latip_pkg::ANGLE_W;

  logic                   rd_valid_q;
  latip_pkg::issue_meta_t meta_q;
  logic                   out_valid_q;
  latip_pkg::out_t        out_q, out_d;
  logic                   adv;

  logic signed [AW_:0]     diff_h, diff_v;
  logic signed [AW_+9:0]   sum_h, sum_v;
  logic signed [AW_-1:0]   h_w;
  logic [AW_-1:0]          v_w;

  assign adv         = rd_valid_q && (!out_valid_q || !out_stall_i);
  assign can_issue_o = !rd_valid_q || adv;

  // a*(256-f) + b*f == a*256 + (b-a)*f; the floor shift is a bit select
  always_comb begin
    diff_h = (AW_+1)'($signed(rdata_b_i[2*AW_-1:AW_])) -
             (AW_+1)'($signed(rdata_a_i[2*AW_-1:AW_]));
    diff_v = (AW_+1)'($signed(rdata_b_i[AW_-1:0])) -
             (AW_+1)'($signed(rdata_a_i[AW_-1:0]));
    sum_h  = (AW_+10)'($signed({rdata_a_i[2*AW_-1:AW_], 8'd0})) +
             (AW_+10)'(diff_h) * (AW_+10)'($signed({1'b0, meta_q.frac}));
    sum_v  = (AW_+10)'($signed({rdata_a_i[AW_-1:0], 8'd0})) +
             (AW_+10)'(diff_v) * (AW_+10)'($signed({1'b0, meta_q.frac}));
    h_w    = sum_h[AW_+7:8];
    v_w    = sum_v[AW_+7:8] + (meta_q.inset ? latip_pkg::INSET_OFFSET : '0);
    out_d.receiver = meta_q.receiver;
    out_d.angle_h  = h_w;
    out_d.angle_v  = v_w;
    out_d.in_view  = (h_w >= -latip_pkg::VIEW_LIMIT) && (h_w <= latip_pkg::VIEW_LIMIT);
    out_d.last     = meta_q.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (issue_i) begin
        rd_valid_q <= 1'b1;
      end else if (adv) begin
        rd_valid_q <= 1'b0;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue_i) begin
      meta_q <= meta_i;
    end
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the lidar angle table interpolator core.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FACETS      = int'(latip_pkg::FacetsDef);
  localparam int COLUMNS     = int'(latip_pkg::ColumnsDef);
  localparam int MAX_SETS    = int'(latip_pkg::MaxSetsDef);
  localparam int RECEIVERS   = int'(latip_pkg::ReceiversDef);
  localparam int TBL_DEPTH   = FACETS * COLUMNS * MAX_SETS * RECEIVERS;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SETTLE      = 40;
  localparam logic [latip_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  logic                            clk       = 1'b0;
  logic                            rst_n     = 1'b0;
  logic                            in_valid  = 1'b0;
  logic                            in_stall;
  latip_pkg::in_t                  in_data   = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  latip_pkg::out_t                 out_data;
  logic                            cfg_we    = 1'b0;
  logic [latip_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [latip_pkg::SET_W-1:0]     cfg_wdata = '0;

  // Shadow copy of the calibration table and the configuration registers
  logic [latip_pkg::WORD_W-1:0] angle_shadow [TBL_DEPTH];
  bit                           loaded       [TBL_DEPTH];
  logic [latip_pkg::SET_W-1:0]  sets_reg  = latip_pkg::SET_COUNT_RST;
  logic [latip_pkg::USED_W-1:0] used_reg  = latip_pkg::RX_USED_RST;
  logic                         inset_reg = latip_pkg::INSET_EN_RST;

  latip_pkg::out_t pending_beams [$];
  int              mismatches  = 0;
  int              cycle_count = 0;
  int              idle_pct    = 13;
  int              stall_pct   = 82;

  lidar_angle_table_interpolator_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL lidar_angle_table_interpolator_core");
      $finish;
    end
  end

  function automatic int eff_sets();
    if (sets_reg == 0) return 1;
    if (int'(sets_reg) > MAX_SETS) return MAX_SETS;
    return int'(sets_reg);
  endfunction

  function automatic int eff_used();
    if (int'(used_reg) > RECEIVERS) return RECEIVERS;
    return int'(used_reg);
  endfunction

  // Flat table index of receiver 0 in the lower (step 0) or upper (step 1) column
  function automatic int lookup_base(logic [1:0] facet, logic signed [15:0] enc,
                                     logic [9:0] line, int step);
    int total;
    int col;
    int sets;
    sets  = eff_sets();
    total = int'(enc) + int'(latip_pkg::ENC_BASE);
    if (total < 0) total = 0;
    col = total >>> latip_pkg::FRAC_W;
    if (col > COLUMNS - 2) col = COLUMNS - 2;
    return (((int'(facet) % FACETS) * COLUMNS + col + step) * sets + int'(line) % sets)
           * RECEIVERS;
  endfunction

  // Floor of the 8-bit fraction blend of two angle words
  function automatic logic signed [latip_pkg::ANGLE_W-1:0] blend(
      logic signed [latip_pkg::ANGLE_W-1:0] a,
      logic signed [latip_pkg::ANGLE_W-1:0] b,
      int frac);
    int s;
    int shifted;
    s       = int'(a) * (256 - frac) + int'(b) * frac;
    shifted = s >>> latip_pkg::FRAC_W;
    return shifted[latip_pkg::ANGLE_W-1:0];
  endfunction

  function automatic void predict_beams(latip_pkg::in_t w);
    int                                   used;
    int                                   total;
    int                                   frac;
    int                                   b1;
    int                                   b2;
    logic [latip_pkg::WORD_W-1:0]         e1;
    logic [latip_pkg::WORD_W-1:0]         e2;
    logic signed [latip_pkg::ANGLE_W-1:0] h;
    logic signed [latip_pkg::ANGLE_W-1:0] v;
    latip_pkg::out_t                      beam;
    used  = eff_used();
    total = int'($signed(w.encoder_angle)) + int'(latip_pkg::ENC_BASE);
    if (total < 0) total = 0;
    frac = total & 255;
    b1   = lookup_base(w.facet, w.encoder_angle, w.scan_line, 0);
    b2   = lookup_base(w.facet, w.encoder_angle, w.scan_line, 1);
    for (int r = 0; r < used; r++) begin
      e1 = angle_shadow[b1 + r];
      e2 = angle_shadow[b2 + r];
      h  = blend(e1[latip_pkg::WORD_W-1:latip_pkg::ANGLE_W],
                 e2[latip_pkg::WORD_W-1:latip_pkg::ANGLE_W], frac);
      v  = blend(e1[latip_pkg::ANGLE_W-1:0], e2[latip_pkg::ANGLE_W-1:0], frac);
      if (inset_reg && int'(w.scan_line) >= eff_sets()) v = v + latip_pkg::INSET_OFFSET;
      beam.receiver = latip_pkg::RX_W'(r);
      beam.angle_h  = h;
      beam.angle_v  = v;
      beam.in_view  = (int'(h) >= -int'(latip_pkg::VIEW_LIMIT)) &&
                      (int'(h) <= int'(latip_pkg::VIEW_LIMIT));
      beam.last     = (r == used - 1);
      pending_beams.push_back(beam);
    end
  endfunction

  function automatic void check_beam(latip_pkg::out_t got);
    latip_pkg::out_t want;
    if (pending_beams.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected word: rx %0d h %0d v %0d view %0b last %0b",
                 got.receiver, got.angle_h, got.angle_v, got.in_view, got.last);
      return;
    end
    want = pending_beams.pop_front();
    if (got.receiver !== want.receiver || got.angle_h !== want.angle_h ||
        got.angle_v !== want.angle_v || got.in_view !== want.in_view ||
        got.last !== want.last) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch: expected rx %0d h %0d v %0d view %0b last %0b",
                 want.receiver, want.angle_h, want.angle_v, want.in_view, want.last);
        $display("          got      rx %0d h %0d v %0d view %0b last %0b",
                 got.receiver, got.angle_h, got.angle_v, got.in_view, got.last);
      end
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_beam(out_data);
  end

  // Called at a falling edge; returns at the falling edge after the word is taken
  task automatic send_word(latip_pkg::in_t w);
    bit taken;
    taken = 1'b0;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    while (!taken) begin
      @(posedge clk);
      taken = !in_stall;
      @(negedge clk);
    end
    if (w.req_type == latip_pkg::REQ_LOAD) begin
      // Drop loads beyond the table
      if (int'(w.entry_address) < TBL_DEPTH) begin
        angle_shadow[w.entry_address] = {w.entry_h, w.entry_v};
        loaded[w.entry_address]       = 1'b1;
      end
    end else begin
      predict_beams(w);
    end
  endtask

  task automatic load_entry(int addr, logic [15:0] h, logic [15:0] v);
    latip_pkg::in_t w;
    w               = '0;
    w.req_type      = latip_pkg::REQ_LOAD;
    w.entry_address = addr[15:0];
    w.entry_h       = h;
    w.entry_v       = v;
    w.facet         = 2'($urandom_range(3));
    w.encoder_angle = 16'($urandom_range(16'hFFFF));
    w.scan_line     = 10'($urandom_range(1023));
    send_word(w);
  endtask

  function automatic logic [15:0] rand_angle();
    case ($urandom_range(7))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return 16'($urandom_range(16'hFFFF));
    endcase
  endfunction

  // Load any entry the lookup will read that holds nothing yet, then send the lookup
  task automatic lookup(logic [1:0] facet, logic signed [15:0] enc, logic [9:0] line);
    latip_pkg::in_t w;
    int             idx;
    for (int r = 0; r < eff_used(); r++) begin
      for (int step = 0; step < 2; step++) begin
        idx = lookup_base(facet, enc, line, step) + r;
        if (!loaded[idx]) load_entry(idx, rand_angle(), rand_angle());
      end
    end
    w               = '0;
    w.req_type      = latip_pkg::REQ_LOOKUP;
    w.entry_address = 16'($urandom_range(16'hFFFF));
    w.entry_h       = 16'($urandom_range(16'hFFFF));
    w.entry_v       = 16'($urandom_range(16'hFFFF));
    w.facet         = facet;
    w.encoder_angle = enc;
    w.scan_line     = line;
    send_word(w);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_beams.size() != 0) @(negedge clk);
    // Hold off for a lookup that emits nothing
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(logic [latip_pkg::CFG_IDX_W-1:0] idx,
                           logic [latip_pkg::SET_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    case (idx)
      latip_pkg::CFG_SET_COUNT: sets_reg  = val;
      latip_pkg::CFG_RX_USED:   used_reg  = val[latip_pkg::USED_W-1:0];
      latip_pkg::CFG_INSET_EN:  inset_reg = val[0];
      default: ;
    endcase
  endtask

  task automatic set_config(int sets, int used, int inset);
    wait_drained();
    write_reg(latip_pkg::CFG_SET_COUNT, latip_pkg::SET_W'(sets));
    write_reg(latip_pkg::CFG_RX_USED, latip_pkg::SET_W'(used));
    write_reg(latip_pkg::CFG_INSET_EN, latip_pkg::SET_W'(inset));
  endtask

  task automatic test_reset_config();
    lookup(2'd1, 16'sd0, 10'd7);
    lookup(2'd1, 16'sd0, 10'd1);
  endtask

  task automatic test_encoder_extremes();
    logic signed [15:0] encs [8];
    encs = '{16'sh8000, -16'sd8193, -16'sd8192, -16'sd8191,
             -16'sd1, 16'sd8191, 16'sd8192, 16'sd32767};
    set_config(6, 2, 1);
    foreach (encs[i]) lookup(2'd0, encs[i], 10'd0);
    lookup(2'd0, 16'sd32767, 10'd1023);
  endtask

  task automatic test_view_and_wrap();
    int b1;
    int b2;
    set_config(6, 2, 1);
    // Column 10, zero fraction: the lower entry passes through, inset wraps v
    b1 = lookup_base(2'd2, -16'sd5632, 10'd6, 0);
    load_entry(b1, 16'sd10922, 16'sh7FFF);
    load_entry(b1 + 1, -16'sd10922, 16'hFFFF);
    lookup(2'd2, -16'sd5632, 10'd6);
    b1 = lookup_base(2'd2, -16'sd5376, 10'd0, 0);
    load_entry(b1, 16'sd10923, 16'h8000);
    load_entry(b1 + 1, -16'sd10923, 16'h0000);
    lookup(2'd2, -16'sd5376, 10'd0);
    // Column 20 with the largest fraction and opposite extremes
    b1 = lookup_base(2'd2, -16'sd2817, 10'd0, 0);
    b2 = lookup_base(2'd2, -16'sd2817, 10'd0, 1);
    load_entry(b1, 16'h8000, 16'h7FFF);
    load_entry(b2, 16'h7FFF, 16'h8000);
    load_entry(b1 + 1, 16'h7FFF, 16'h8000);
    load_entry(b2 + 1, 16'h8000, 16'h7FFF);
    lookup(2'd2, -16'sd2817, 10'd0);
  endtask

  task automatic test_load_range();
    set_config(MAX_SETS, RECEIVERS, 1);
    load_entry(TBL_DEPTH - 1, 16'h7FFF, 16'h8000);
    load_entry(TBL_DEPTH, rand_angle(), rand_angle());
    load_entry(32'h0000_FFFF, rand_angle(), rand_angle());
    lookup(2'd3, 16'sd32767, 10'd23);
    lookup(2'd3, 16'sd32767, 10'd1023);
  endtask

  task automatic test_config_corners();
    set_config(0, 3, 1);
    lookup(2'd1, 16'sd100, 10'd0);
    lookup(2'd1, 16'sd100, 10'd1);
    set_config(31, 3, 1);
    lookup(2'd1, 16'sd100, 10'd24);
    lookup(2'd1, 16'sd100, 10'd30);
    set_config(6, 0, 1);
    lookup(2'd1, 16'sd100, 10'd5);
    set_config(6, 15, 0);
    lookup(2'd1, 16'sd100, 10'd1023);
    wait_drained();
    write_reg(CFG_SPARE, 5'h1F);
    lookup(2'd1, 16'sd100, 10'd1023);
  endtask

  task automatic test_random();
    logic [15:0] enc;
    logic [9:0]  line;
    int          addr;
    int          s;
    int          u;
    for (int seg = 0; seg < 6; seg++) begin
      wait_drained();
      if (seg == 2) begin
        idle_pct  = 82;
        stall_pct = 13;
      end else if (seg == 4) begin
        idle_pct  = 0;
        stall_pct = 0;
      end
      case (seg)
        0: set_config(1, 1, 0);
        1: set_config(MAX_SETS, RECEIVERS, 1);
        default: begin
          s = ($urandom_range(7) == 0) ? ($urandom_range(1) ? 0 : 31)
                                       : $urandom_range(1, MAX_SETS);
          u = ($urandom_range(7) == 0) ? ($urandom_range(1) ? 0 : 15)
                                       : $urandom_range(1, RECEIVERS);
          set_config(s, u, $urandom_range(1));
        end
      endcase
      for (int k = 0; k < 5; k++) begin
        if ($urandom_range(39) == 0) wait_drained();
        enc  = $urandom_range(1) ? 16'($urandom_range(16'hFFFF))
                                 : 16'($urandom_range(16383) - 8192);
        line = $urandom_range(1) ? 10'($urandom_range(1023))
                                 : 10'($urandom_range(2 * eff_sets()));
        if ($urandom_range(3) == 0) begin
          // Overwrite an entry a lookup may read, or hit any address
          if ($urandom_range(1))
            addr = lookup_base(2'($urandom_range(3)), enc, line, $urandom_range(1))
                   + $urandom_range(RECEIVERS - 1);
          else
            addr = $urandom_range(16'hFFFF);
          load_entry(addr, rand_angle(), rand_angle());
        end else begin
          lookup(2'($urandom_range(3)), enc, line);
        end
      end
    end
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_reset_config();
    test_encoder_extremes();
    test_view_and_wrap();
    test_load_range();
    test_config_corners();
    test_random();
    wait_drained();
    if (mismatches == 0 && pending_beams.size() == 0) begin
      $display("PASS lidar_angle_table_interpolator_core");
    end else begin
      $display("FAIL lidar_angle_table_interpolator_core");
    end
    $finish;
  end

endmodule

/* lidar_angle_table_interpolator_core.f */
rtl/latip_pkg.sv
rtl/latip_div.sv
rtl/latip_mem.sv
rtl/latip_out.sv
rtl/lidar_angle_table_interpolator_core.sv
tb/tb_top.sv
